/* hdl/modular_square_root_defines.svh */
// Assertion macros shared by the modular square root checker.
// Included by file name only; no other dependencies.
`ifndef MODULAR_SQUARE_ROOT_DEFINES_SVH
`define MODULAR_SQUARE_ROOT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MSQR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MSQR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/msqr_pkg.sv */
// Shared types and constants for the modular square root block.
// No dependencies.
`timescale 1ns / 1ps

package msqr_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_BITS = 7;
    localparam int Z_BITS = 17;
    localparam logic [Z_BITS-1:0] NONRES_LIMIT = 17'd65536;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONRES = 2'd1;
    localparam logic [1:0] ST_FAIL   = 2'd2;

    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_MOD = 1'b1
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_arith_req;

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_REDW   = 21'h000002,
        S_JMODW  = 21'h000004,
        S_JLOOP  = 21'h000008,
        S_CHKA   = 21'h000010,
        S_SPLIT  = 21'h000020,
        S_CHKZ   = 21'h000040,
        S_GOTB   = 21'h000080,
        S_GOTF   = 21'h000100,
        S_OUTER  = 21'h000200,
        S_INNER  = 21'h000400,
        S_INNERW = 21'h000800,
        S_STEP2  = 21'h001000,
        S_STEPW  = 21'h002000,
        S_FIN1   = 21'h004000,
        S_FIN2   = 21'h008000,
        S_FIN3   = 21'h010000,
        S_PLOOP  = 21'h020000,
        S_PM1W   = 21'h040000,
        S_PM2W   = 21'h080000,
        S_DONE   = 21'h100000
    } t_state;

endpackage

/* hdl/modular_square_root.sv */
// Modular square root (Tonelli-Shanks) top level: sequencer around one serial unit.
// Depends on msqr_pkg and msqr_arith.
//
// Input channel: i_in_valid / o_in_ready carry i_value and i_modulus (odd prime p).
// Output channel: o_out_valid / i_out_ready carry o_root and o_status
// (0 root found, 1 non-residue, 2 bad modulus or search failed).
// One result beat per input beat, in order. o_in_ready is high only while the
// sequencer is idle; a new beat may be taken while the last result still waits.
// Latency is data dependent. Every modular multiply or reduction runs on one
// shared bit-serial unit. A power takes up to 64 squarings and 64 multiplies.
// A root costs four powers plus one power per order step, and one Jacobi test
// for the value and one per candidate z; a bad modulus goes straight to done.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_out_valid. When the receiver stalls, the result holds and a finished item
// waits before its result register until the previous beat is taken.
`timescale 1ns / 1ps

module modular_square_root (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [msqr_pkg::WORD_BITS-1:0]  i_value,
    input  logic [msqr_pkg::WORD_BITS-1:0]  i_modulus,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [msqr_pkg::WORD_BITS-1:0]  o_root,
    output logic [1:0]                      o_status
);

    localparam int W = msqr_pkg::WORD_BITS;
    localparam int C = msqr_pkg::CNT_BITS;
    localparam int Z = msqr_pkg::Z_BITS;

    msqr_pkg::t_state       r_state;
    msqr_pkg::t_state       r_jret;
    msqr_pkg::t_state       r_pret;
    msqr_pkg::t_arith_req   r_req;
    logic [W-1:0]           r_opx;
    logic [W-1:0]           r_opy;
    logic [W-1:0]           r_opm;

    logic [W-1:0]           r_p;
    logic [W-1:0]           r_a;
    logic [W-1:0]           r_h;
    logic [C-1:0]           r_k;
    logic [Z-1:0]           r_z;
    logic [W-1:0]           r_b;
    logic [W-1:0]           r_f;
    logic [W-1:0]           r_l;
    logic [W-1:0]           r_sq;
    logic [C-1:0]           r_m;
    logic [C-1:0]           r_bound;

    logic [W-1:0]           r_ja;
    logic [W-1:0]           r_jn;
    logic                   r_jt;
    logic                   r_jneg;

    logic [W-1:0]           r_px;
    logic [W-1:0]           r_pe;
    logic [W-1:0]           r_pr;

    logic [W-1:0]           r_fin_root;
    logic [1:0]             r_fin_status;
    logic                   r_ovalid;
    logic [W-1:0]           r_root;
    logic [1:0]             r_status;

    logic                   w_done;
    logic [W-1:0]           w_res;
    logic [W-1:0]           w_step;
    logic [C-1:0]           w_m1;
    logic [Z-1:0]           w_z1;

    msqr_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_x     (r_opx),
        .i_y     (r_opy),
        .i_m     (r_opm),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    assign w_step = {{(W-1){1'b0}}, 1'b1} << (r_k - r_m);
    assign w_m1   = r_m + 1'b1;
    assign w_z1   = r_z + 1'b1;

    always_ff @(posedge i_clk) begin
        msqr_pkg::t_arith_req n_req;
        if (!i_rst_n) begin
            r_state  <= msqr_pkg::S_IDLE;
            r_req    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            n_req = '0;
            if (r_ovalid && i_out_ready && r_state != msqr_pkg::S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                msqr_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_modulus < W'(3) || !i_modulus[0]) begin
                            r_fin_root   <= '0;
                            r_fin_status <= msqr_pkg::ST_FAIL;
                            r_state      <= msqr_pkg::S_DONE;
                        end else begin
                            r_p     <= i_modulus;
                            n_req   = '{start: 1'b1, op: msqr_pkg::OP_MOD};
                            r_opx   <= i_value;
                            r_opm   <= i_modulus;
                            r_state <= msqr_pkg::S_REDW;
                        end
                    end
                end
                msqr_pkg::S_REDW: begin
                    if (w_done) begin
                        r_a <= w_res;
                        if (w_res == '0) begin
                            r_fin_root   <= '0;
                            r_fin_status <= msqr_pkg::ST_OK;
                            r_state      <= msqr_pkg::S_DONE;
                        end else begin
                            r_jt    <= 1'b0;
                            r_jn    <= r_p;
                            r_jret  <= msqr_pkg::S_CHKA;
                            n_req   = '{start: 1'b1, op: msqr_pkg::OP_MOD};
                            r_opx   <= w_res;
                            r_opm   <= r_p;
                            r_state <= msqr_pkg::S_JMODW;
                        end
                    end
                end
                // Jacobi symbol: binary reduction with reciprocity swaps
                msqr_pkg::S_JMODW: begin
                    if (w_done) begin
                        r_ja    <= w_res;
                        r_state <= msqr_pkg::S_JLOOP;
                    end
                end
                msqr_pkg::S_JLOOP: begin
                    if (r_ja == '0) begin
                        r_jneg  <= (r_jn == W'(1)) && r_jt;
                        r_state <= r_jret;
                    end else if (!r_ja[0]) begin
                        r_ja <= r_ja >> 1;
                        if (r_jn[2:0] == 3'd3 || r_jn[2:0] == 3'd5) begin
                            r_jt <= !r_jt;
                        end
                    end else begin
                        if (r_ja[1:0] == 2'd3 && r_jn[1:0] == 2'd3) begin
                            r_jt <= !r_jt;
                        end
                        r_jn    <= r_ja;
                        n_req   = '{start: 1'b1, op: msqr_pkg::OP_MOD};
                        r_opx   <= r_jn;
                        r_opm   <= r_ja;
                        r_state <= msqr_pkg::S_JMODW;
                    end
                end
                msqr_pkg::S_CHKA: begin
                    if (r_jneg) begin
                        r_fin_root   <= '0;
                        r_fin_status <= msqr_pkg::ST_NONRES;
                        r_state      <= msqr_pkg::S_DONE;
                    end else begin
                        r_h     <= r_p - 1'b1;
                        r_k     <= '0;
                        r_state <= msqr_pkg::S_SPLIT;
                    end
                end
                msqr_pkg::S_SPLIT: begin
                    if (!r_h[0]) begin
                        r_h <= r_h >> 1;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_z     <= Z'(1);
                        r_jt    <= 1'b0;
                        r_jn    <= r_p;
                        r_jret  <= msqr_pkg::S_CHKZ;
                        n_req   = '{start: 1'b1, op: msqr_pkg::OP_MOD};
                        r_opx   <= W'(1);
                        r_opm   <= r_p;
                        r_state <= msqr_pkg::S_JMODW;
                    end
                end
                msqr_pkg::S_CHKZ: begin
                    if (r_jneg) begin
                        r_px    <= r_a;
                        r_pe    <= r_h;
                        r_pr    <= W'(1);
                        r_pret  <= msqr_pkg::S_GOTB;
                        r_state <= msqr_pkg::S_PLOOP;
                    end else if (w_z1 > msqr_pkg::NONRES_LIMIT || W'(w_z1) >= r_p) begin
                        r_fin_root   <= '0;
                        r_fin_status <= msqr_pkg::ST_FAIL;
                        r_state      <= msqr_pkg::S_DONE;
                    end else begin
                        r_z     <= w_z1;
                        r_jt    <= 1'b0;
                        r_jn    <= r_p;
                        r_jret  <= msqr_pkg::S_CHKZ;
                        n_req   = '{start: 1'b1, op: msqr_pkg::OP_MOD};
                        r_opx   <= W'(w_z1);
                        r_opm   <= r_p;
                        r_state <= msqr_pkg::S_JMODW;
                    end
                end
                msqr_pkg::S_GOTB: begin
                    r_b     <= r_pr;
                    r_px    <= W'(r_z);
                    r_pe    <= r_h;
                    r_pr    <= W'(1);
                    r_pret  <= msqr_pkg::S_GOTF;
                    r_state <= msqr_pkg::S_PLOOP;
                end
                msqr_pkg::S_GOTF: begin
                    r_f     <= r_pr;
                    r_l     <= '0;
                    r_bound <= r_k;
                    r_state <= msqr_pkg::S_OUTER;
                end
                msqr_pkg::S_OUTER: begin
                    if (r_b == W'(1)) begin
                        r_px    <= r_a;
                        r_pe    <= (r_h >> 1) + 1'b1;
                        r_pr    <= W'(1);
                        r_pret  <= msqr_pkg::S_FIN1;
                        r_state <= msqr_pkg::S_PLOOP;
                    end else begin
                        r_m     <= '0;
                        r_sq    <= r_b;
                        r_state <= msqr_pkg::S_INNER;
                    end
                end
                // order search: square until 1, bounded by the previous order
                msqr_pkg::S_INNER: begin
                    if (r_sq == W'(1)) begin
                        r_px    <= r_f;
                        r_pe    <= w_step;
                        r_pr    <= W'(1);
                        r_pret  <= msqr_pkg::S_STEP2;
                        r_state <= msqr_pkg::S_PLOOP;
                    end else if (w_m1 >= r_bound) begin
                        r_fin_root   <= '0;
                        r_fin_status <= msqr_pkg::ST_FAIL;
                        r_state      <= msqr_pkg::S_DONE;
                    end else begin
                        r_m     <= w_m1;
                        n_req   = '{start: 1'b1, op: msqr_pkg::OP_MUL};
                        r_opx   <= r_sq;
                        r_opy   <= r_sq;
                        r_opm   <= r_p;
                        r_state <= msqr_pkg::S_INNERW;
                    end
                end
                msqr_pkg::S_INNERW: begin
                    if (w_done) begin
                        r_sq    <= w_res;
                        r_state <= msqr_pkg::S_INNER;
                    end
                end
                msqr_pkg::S_STEP2: begin
                    n_req   = '{start: 1'b1, op: msqr_pkg::OP_MUL};
                    r_opx   <= r_b;
                    r_opy   <= r_pr;
                    r_opm   <= r_p;
                    r_state <= msqr_pkg::S_STEPW;
                end
                msqr_pkg::S_STEPW: begin
                    if (w_done) begin
                        r_b     <= w_res;
                        r_l     <= r_l + w_step;
                        r_bound <= r_m;
                        r_state <= msqr_pkg::S_OUTER;
                    end
                end
                msqr_pkg::S_FIN1: begin
                    r_sq    <= r_pr;
                    r_px    <= r_f;
                    r_pe    <= r_l >> 1;
                    r_pr    <= W'(1);
                    r_pret  <= msqr_pkg::S_FIN2;
                    r_state <= msqr_pkg::S_PLOOP;
                end
                msqr_pkg::S_FIN2: begin
                    n_req   = '{start: 1'b1, op: msqr_pkg::OP_MUL};
                    r_opx   <= r_sq;
                    r_opy   <= r_pr;
                    r_opm   <= r_p;
                    r_state <= msqr_pkg::S_FIN3;
                end
                msqr_pkg::S_FIN3: begin
                    if (w_done) begin
                        r_fin_root   <= w_res;
                        r_fin_status <= msqr_pkg::ST_OK;
                        r_state      <= msqr_pkg::S_DONE;
                    end
                end
                // right-to-left power: r_pr = r_px ^ r_pe mod p
                msqr_pkg::S_PLOOP: begin
                    if (r_pe == '0) begin
                        r_state <= r_pret;
                    end else if (r_pe[0]) begin
                        n_req   = '{start: 1'b1, op: msqr_pkg::OP_MUL};
                        r_opx   <= r_pr;
                        r_opy   <= r_px;
                        r_opm   <= r_p;
                        r_state <= msqr_pkg::S_PM1W;
                    end else begin
                        n_req   = '{start: 1'b1, op: msqr_pkg::OP_MUL};
                        r_opx   <= r_px;
                        r_opy   <= r_px;
                        r_opm   <= r_p;
                        r_state <= msqr_pkg::S_PM2W;
                    end
                end
                msqr_pkg::S_PM1W: begin
                    if (w_done) begin
                        r_pr    <= w_res;
                        n_req   = '{start: 1'b1, op: msqr_pkg::OP_MUL};
                        r_opx   <= r_px;
                        r_opy   <= r_px;
                        r_opm   <= r_p;
                        r_state <= msqr_pkg::S_PM2W;
                    end
                end
                msqr_pkg::S_PM2W: begin
                    if (w_done) begin
                        r_px    <= w_res;
                        r_pe    <= r_pe >> 1;
                        r_state <= msqr_pkg::S_PLOOP;
                    end
                end
                msqr_pkg::S_DONE: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_root   <= r_fin_root;
                        r_status <= r_fin_status;
                        r_state  <= msqr_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= msqr_pkg::S_IDLE;
                end
            endcase
            r_req <= n_req;
        end
    end

    assign o_in_ready  = (r_state == msqr_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_root      = r_root;
    assign o_status    = r_status;

endmodule

/* hdl/msqr_arith.sv */
// Bit-serial modular unit: x*y mod m (double-and-add) or x mod m (shift-subtract).
// Depends on msqr_pkg.
`timescale 1ns / 1ps

module msqr_arith (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msqr_pkg::t_arith_req                i_req,
    input  logic [msqr_pkg::WORD_BITS-1:0]      i_x,
    input  logic [msqr_pkg::WORD_BITS-1:0]      i_y,
    input  logic [msqr_pkg::WORD_BITS-1:0]      i_m,
    output logic                                o_done,
    output logic [msqr_pkg::WORD_BITS-1:0]      o_res
);

    localparam int IDX_BITS = $clog2(msqr_pkg::WORD_BITS);

    logic                               r_busy;
    logic                               r_done;
    logic                               r_add;
    msqr_pkg::t_op                      r_op;
    logic [IDX_BITS-1:0]                r_idx;
    logic [msqr_pkg::WORD_BITS-1:0]     r_x;
    logic [msqr_pkg::WORD_BITS-1:0]     r_y;
    logic [msqr_pkg::WORD_BITS-1:0]     r_m;
    logic [msqr_pkg::WORD_BITS-1:0]     r_r;

    logic                               w_cin;
    logic [msqr_pkg::WORD_BITS:0]       w_sum;
    logic [msqr_pkg::WORD_BITS:0]       w_diff;
    logic [msqr_pkg::WORD_BITS-1:0]     w_red;
    logic                               w_adv;

    // doubling step shifts in the dividend bit for mod; add step adds x
    assign w_cin  = !r_add && (r_op == msqr_pkg::OP_MOD) && r_x[r_idx];
    assign w_sum  = {1'b0, r_r} + {1'b0, (r_add ? r_x : r_r)}
                  + {{msqr_pkg::WORD_BITS{1'b0}}, w_cin};
    assign w_diff = w_sum - {1'b0, r_m};
    assign w_red  = w_diff[msqr_pkg::WORD_BITS] ? w_sum[msqr_pkg::WORD_BITS-1:0]
                                                : w_diff[msqr_pkg::WORD_BITS-1:0];
    assign w_adv  = r_add || !((r_op == msqr_pkg::OP_MUL) && r_y[r_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_add  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_add  <= 1'b0;
                r_op   <= i_req.op;
                r_idx  <= IDX_BITS'(msqr_pkg::WORD_BITS - 1);
                r_x    <= i_x;
                r_y    <= i_y;
                r_m    <= i_m;
                r_r    <= '0;
            end else if (r_busy) begin
                r_r <= w_red;
                if (w_adv) begin
                    r_add <= 1'b0;
                    if (r_idx == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end else begin
                    r_add <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_r;

endmodule

/* hdl/msqr_checker.sv */
// Port-level checker for the modular square root block, bound to the top level.
// Depends on msqr_pkg and modular_square_root_defines.svh.
`timescale 1ns / 1ps
`include "modular_square_root_defines.svh"

module msqr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic [msqr_pkg::WORD_BITS-1:0]   i_value,
    input logic [msqr_pkg::WORD_BITS-1:0]   i_modulus,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [msqr_pkg::WORD_BITS-1:0]   o_root,
    input logic [1:0]                       o_status
);

    `MSQR_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out_valid, (o_status == msqr_pkg::ST_OK || o_status == msqr_pkg::ST_NONRES || o_status == msqr_pkg::ST_FAIL), "undefined status code")

    `MSQR_ASSERT_IMP(a_no_root_zero, i_clk, i_rst_n, o_out_valid && o_status != msqr_pkg::ST_OK, o_root == '0, "failed result carries a nonzero root")

    `MSQR_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready again right after an input beat")

    `MSQR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_root) && $stable(o_status), "stalled result changed")

    `MSQR_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_value) && $stable(i_modulus), "waiting input beat changed")

endmodule

bind modular_square_root msqr_checker u_msqr_checker (.*);
